>>> rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types, constants and the order key for the rank selector.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int MAX_ITEMS_DEF = 4096;

    // Request passed from the load front end to the select engine
    typedef struct packed {
        logic [11:0] rank;
        logic        rank_bad;
    } t_sel_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WIN,
        S_RD_MID,
        S_RD_HIGH,
        S_MED,
        S_RD_PIV,
        S_PIV,
        S_SCAN_RD,
        S_SCAN,
        S_SWAP_RD,
        S_SWAP_WR,
        S_DECIDE,
        S_FIN_RD,
        S_DONE
    } t_sel_state;

    // Order-preserving key: both zeros map together
    function automatic logic [31:0] order_key(input logic [31:0] bits);
        logic [31:0] k;
        if (bits[30:0] == 31'd0) begin
            k = 32'h8000_0000;
        end else if (bits[31]) begin
            k = ~bits;
        end else begin
            k = bits | 32'h8000_0000;
        end
        return k;
    endfunction

endpackage

>>> rtl/kth_smallest_select.sv
// ----------------------------------------------------------------------------
// kth_smallest_select
// Rank selector over a loaded set of single-precision values.
// ----------------------------------------------------------------------------
// Usage: drive i_sample_bits with start high while busy is low; one value
// is taken per cycle. The request with i_last_item high closes the set and
// carries i_wanted_rank. busy then stays high while the select engine
// walks the sample memory, and one result appears for a single cycle with
// o_valid high: o_selected_bits and o_rank_error.
// A rank outside the set is answered without walking the memory. Otherwise
// each quickselect round reads the low, middle and high entries for the
// pivot, then partitions the window in place, writing each swap in halves.
// Values beyond MAX_ITEMS are dropped, the last one still closes the set.
// Reset (synchronous, active low) clears counts and the engine state; the
// memory holds no reset value. The receiver cannot stall: the result is
// shown for exactly one cycle.
// ----------------------------------------------------------------------------
module kth_smallest_select #(
    parameter int MAX_ITEMS = kss_pkg::MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_sample_bits,
    input  logic [11:0] i_wanted_rank,
    input  logic        i_last_item,
    output logic        o_valid,
    output logic [31:0] o_selected_bits,
    output logic        o_rank_error
);
    import kss_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);

    logic          w_take, w_wr_en, w_req_valid, w_req_pop, w_busy;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic [AW:0]   w_count;
    t_sel_req      w_req;

    assign busy   = w_busy;
    assign w_take = start && !w_busy;

    kss_front #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_front (
        .i_clk, .i_rst_n, .i_take(w_take), .i_sample_bits, .i_wanted_rank,
        .i_last_item, .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data), .o_req_valid(w_req_valid), .o_req(w_req),
        .o_count(w_count), .i_req_pop(w_req_pop)
    );

    kss_engine #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_engine (
        .i_clk, .i_rst_n, .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data), .i_req_valid(w_req_valid), .i_req(w_req),
        .i_count(w_count), .o_req_pop(w_req_pop), .o_busy(w_busy),
        .o_valid, .o_selected_bits, .o_rank_error
    );

endmodule

>>> rtl/kss_front.sv
// ----------------------------------------------------------------------------
// kss_front
// Load front end: writes samples, counts them, queues a select request.
// ----------------------------------------------------------------------------
module kss_front #(
    parameter int MAX_ITEMS = kss_pkg::MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [31:0]       i_sample_bits,
    input  logic [11:0]       i_wanted_rank,
    input  logic              i_last_item,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [31:0]       o_wr_data,
    output logic              o_req_valid,
    output kss_pkg::t_sel_req o_req,
    output logic [AW:0]       o_count,
    input  logic              i_req_pop
);
    import kss_pkg::*;

    logic [AW:0] r_count;
    logic [AW:0] r_sel_count;
    logic        r_req_valid;
    t_sel_req    r_req;
    logic        w_room;
    logic [AW:0] w_cnt_next;

    assign w_room     = (r_count < (AW+1)'(MAX_ITEMS));
    assign w_cnt_next = w_room ? r_count + 1'b1 : r_count;
    assign o_wr_en    = i_take && w_room;
    assign o_wr_addr  = r_count[AW-1:0];
    assign o_wr_data  = i_sample_bits;

    // Item counter and one-entry request queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_req_valid <= 1'b0;
            r_sel_count <= '0;
        end else begin
            if (i_req_pop) r_req_valid <= 1'b0;
            if (i_take) begin
                if (i_last_item) begin
                    r_count     <= '0;
                    r_req_valid <= 1'b1;
                    r_sel_count <= w_cnt_next;
                end else begin
                    r_count <= w_cnt_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last_item) begin
            r_req.rank     <= i_wanted_rank;
            r_req.rank_bad <= ((AW+1)'(i_wanted_rank) >= w_cnt_next) ||
                              (AW < 12 && (i_wanted_rank >> AW) != '0);
        end
    end

    assign o_req_valid = r_req_valid;
    assign o_req       = r_req;
    assign o_count     = r_sel_count;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(MAX_ITEMS)) else $error("count overflow");
    a_req_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_pop && !(i_take && i_last_item)) |=> !r_req_valid)
        else $error("request not cleared");
    a_last_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last_item) |=> (r_count == '0 && r_req_valid))
        else $error("last item not closing set");

endmodule

>>> rtl/kss_engine.sv
// ----------------------------------------------------------------------------
// kss_engine
// Select engine: quickselect with median-of-three and three-way partition.
// ----------------------------------------------------------------------------
module kss_engine #(
    parameter int MAX_ITEMS = kss_pkg::MAX_ITEMS_DEF,
    parameter int AW        = $clog2(MAX_ITEMS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic              i_req_valid,
    input  kss_pkg::t_sel_req i_req,
    input  logic [AW:0]       i_count,
    output logic              o_req_pop,
    output logic              o_busy,
    output logic              o_valid,
    output logic [31:0]       o_selected_bits,
    output logic              o_rank_error
);
    import kss_pkg::*;

    logic [31:0] r_mem [MAX_ITEMS];
    logic [31:0] r_rd;

    t_sel_state r_state, n_state;
    logic [AW-1:0] r_lo, r_hi, r_lt, r_gt, r_rank;
    logic [AW:0]   r_i;     // scan index, may step one past the top entry
    logic [31:0]   r_a, r_b, r_piv, r_x;
    logic          r_stop;
    logic          r_valid, r_err;
    logic [31:0]   r_out;

    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [31:0]     w_wdata;
    logic [AW-1:0]   w_mid;
    logic [31:0]     w_ka, w_kb, w_kc, w_kv, w_kp, w_med;
    logic            w_accept;

    assign w_accept = (r_state == S_IDLE) && i_req_valid;
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_ka = order_key(r_a);
    assign w_kb = order_key(r_b);
    assign w_kc = order_key(r_rd);
    assign w_kv = order_key(r_rd);
    assign w_kp = order_key(r_piv);

    // Median of three values: a = low, b = middle, c = high
    always_comb begin
        if (w_ka < w_kb) begin
            if (w_kb < w_kc)      w_med = r_b;
            else if (w_ka < w_kc) w_med = r_rd;
            else                  w_med = r_a;
        end else begin
            if (w_ka < w_kc)      w_med = r_a;
            else if (w_kb < w_kc) w_med = r_rd;
            else                  w_med = r_b;
        end
    end

    // Memory read address per state
    always_comb begin
        unique case (r_state)
            S_WIN:     w_raddr = r_lo;
            S_RD_MID:  w_raddr = w_mid;
            S_RD_HIGH: w_raddr = r_hi;
            S_SCAN:    w_raddr = (w_kv > w_kp) ? r_gt : r_lt;
            S_DECIDE:  w_raddr = r_lo;
            default:   w_raddr = r_i[AW-1:0];
        endcase
    end

    // Memory write port: load, or the two halves of a swap
    always_comb begin
        w_we    = i_wr_en;
        w_waddr = i_wr_addr;
        w_wdata = i_wr_data;
        if (r_state == S_SWAP_RD) begin
            w_we    = 1'b1;
            w_waddr = r_i[AW-1:0];
            w_wdata = r_rd;
        end else if (r_state == S_SWAP_WR) begin
            w_we    = 1'b1;
            w_waddr = r_stop ? r_lt : r_gt;
            w_wdata = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_req_valid) n_state = i_req.rank_bad ? S_DONE : S_WIN;
            S_WIN:     n_state = (r_lo == r_hi) ? S_FIN_RD : S_RD_MID;
            S_RD_MID:  n_state = S_RD_HIGH;
            S_RD_HIGH: n_state = S_MED;
            S_MED:     n_state = S_SCAN_RD;
            S_RD_PIV:  n_state = S_PIV;
            S_PIV:     n_state = S_SCAN_RD;
            S_SCAN_RD: n_state = (r_i <= {1'b0, r_gt} && !r_stop) ? S_SCAN : S_DECIDE;
            S_SCAN:    n_state = (w_kv == w_kp) ? S_SCAN_RD : S_SWAP_RD;
            S_SWAP_RD: n_state = S_SWAP_WR;
            S_SWAP_WR: n_state = S_SCAN_RD;
            S_DECIDE: begin
                if (r_rank < r_lt)      n_state = (r_lt == '0) ? S_FIN_RD : S_WIN;
                else if (r_rank > r_gt) n_state = S_WIN;
                else                    n_state = S_DONE;
            end
            S_FIN_RD:  n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                r_lo   <= '0;
                r_hi   <= AW'(i_count - 1'b1);
                r_rank <= AW'(i_req.rank);
                r_err  <= i_req.rank_bad;
                r_out  <= '0;
            end
            S_WIN:     r_i <= {1'b0, r_lo};
            S_RD_MID:  r_a <= r_rd;
            S_RD_HIGH: r_b <= r_rd;
            S_MED: begin
                r_piv  <= w_med;
                r_lt   <= r_lo;
                r_i    <= {1'b0, r_lo};
                r_gt   <= r_hi;
                r_stop <= 1'b0;
            end
            S_SCAN: begin
                r_x <= r_rd;
                if (w_kv == w_kp) r_i <= r_i + 1'b1;
                r_stop <= (w_kv < w_kp);
            end
            S_SWAP_WR: begin
                if (r_stop) begin
                    r_lt   <= r_lt + 1'b1;
                    r_i    <= r_i + 1'b1;
                    r_stop <= 1'b0;
                end else begin
                    r_stop <= (r_gt == '0);
                    if (r_gt != '0) r_gt <= r_gt - 1'b1;
                end
            end
            S_DECIDE: begin
                if (r_rank < r_lt) begin
                    if (r_lt == '0) r_lo <= '0;
                    else r_hi <= r_lt - 1'b1;
                end else if (r_rank > r_gt) begin
                    r_lo <= r_gt + 1'b1;
                end else begin
                    r_out <= r_piv;
                end
            end
            S_FIN_RD:  r_out <= r_rd;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= (r_state == S_DONE);
    end

    assign o_req_pop       = w_accept;
    assign o_busy          = (r_state != S_IDLE) || i_req_valid;
    assign o_valid         = r_valid;
    assign o_selected_bits = r_out;
    assign o_rank_error    = r_err;

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("double strobe");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE && r_valid))
        else $error("done not followed by strobe");
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_lt} <= r_i)) else $error("partition order");

endmodule
